/* sv/awvn_pkg.sv */
`timescale 1ns / 1ps

package awvn_pkg;

    localparam int MAX_VERTICES = 1024;            // power of two
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int INDEX_W      = 10;
    localparam int POS_W        = 16;
    localparam int ACC_W        = 48;
    localparam int FIFO_DEPTH   = 4;               // power of two

    localparam logic [33:0]        LEN_FLOOR  = 34'd7;
    localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
    localparam logic [16:0]        PI_Q14     = 17'd51472;
    localparam logic [15:0]        ANGLE_MIN  = 16'd2;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic [33:0]        ONE_Q28    = 34'd268435456;
    localparam logic [33:0]        SQ_BIT0    = 34'd4294967296;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TRI  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                     kind;
        logic [IDX_W-1:0]        idx_a;
        logic [IDX_W-1:0]        idx_b;
        logic [IDX_W-1:0]        idx_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_cmd;

    // Arctangent of 2^-i in Q.16.
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

/* sv/angle_weighted_vertex_normals_unit.sv */
`timescale 1ns / 1ps

// Angle-weighted vertex normal accumulator. Opcode 0 stores a Q7.8 vertex position and
// zeroes that vertex's normal, opcode 1 adds the triangle's cross product, weighted by
// each corner's interior angle (Q2.14), into the three corner normals with saturation,
// and opcode 2 returns one accumulated normal; every word gives exactly one result word.
// Input words pass into a four-entry queue and are executed one at a time by a sequencer
// with a single shared multiplier. A triangle's run time is set mostly by the 17-step
// square root run three times per corner, the 14-step divider, which is skipped when the
// cosine clips, and the 16-step arc tangent rotation. Reading a normal or using a position
// that was never loaded returns undefined data.
module angle_weighted_vertex_normals_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_opcode,
    input  logic [awvn_pkg::INDEX_W-1:0]       i_index_a,
    input  logic [awvn_pkg::INDEX_W-1:0]       i_index_b,
    input  logic [awvn_pkg::INDEX_W-1:0]       i_index_c,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_pos_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [awvn_pkg::ACC_W-1:0]  o_normal_x,
    output logic signed [awvn_pkg::ACC_W-1:0]  o_normal_y,
    output logic signed [awvn_pkg::ACC_W-1:0]  o_normal_z,
    output logic                               o_saturated
);

    import awvn_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    awvn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_index_a   (i_index_a),
        .i_index_b   (i_index_b),
        .i_index_c   (i_index_c),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    awvn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y),
        .o_normal_z  (o_normal_z),
        .o_saturated (o_saturated)
    );

    // The sequencer only takes a word that the queue holds.
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("queue popped while empty");

    // A flagged triangle result never carries normal data.
    a_sat_only_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0))
        else $error("saturation flag on a result with normal data");

    // Reset leaves both the queue and the output register empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !cmd_valid))
        else $error("queue or output not empty after reset");

endmodule

/* sv/awvn_ram.sv */
`timescale 1ns / 1ps

module awvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/awvn_front.sv */
`timescale 1ns / 1ps

module awvn_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_opcode,
    input  logic [awvn_pkg::INDEX_W-1:0]        i_index_a,
    input  logic [awvn_pkg::INDEX_W-1:0]        i_index_b,
    input  logic [awvn_pkg::INDEX_W-1:0]        i_index_c,
    input  logic signed [awvn_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [awvn_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [awvn_pkg::POS_W-1:0]   i_pos_z,
    output awvn_pkg::t_cmd                      o_cmd,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_pop
);

    import awvn_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    t_cmd          r_q [FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    t_cmd          in_cmd;
    logic          push;

    // Decode the word into a command; indices wrap to the store size.
    always_comb begin
        in_cmd.kind  = t_op'(i_opcode);
        in_cmd.idx_a = IDX_W'(i_index_a % MAX_VERTICES);
        in_cmd.idx_b = IDX_W'(i_index_b % MAX_VERTICES);
        in_cmd.idx_c = IDX_W'(i_index_c % MAX_VERTICES);
        in_cmd.pos_x = i_pos_x;
        in_cmd.pos_y = i_pos_y;
        in_cmd.pos_z = i_pos_z;
    end

    assign o_stall     = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_cmd_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= in_cmd;
        end
    end

endmodule

/* sv/awvn_back.sv */
`timescale 1ns / 1ps

module awvn_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  awvn_pkg::t_cmd                     i_cmd,
    input  logic                               i_cmd_valid,
    output logic                               o_cmd_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [awvn_pkg::ACC_W-1:0]  o_normal_x,
    output logic signed [awvn_pkg::ACC_W-1:0]  o_normal_y,
    output logic signed [awvn_pkg::ACC_W-1:0]  o_normal_z,
    output logic                               o_saturated
);

    import awvn_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_READ, S_PRD, S_CROSS, S_LEN, S_SQRT, S_LP,
        S_DIV, S_CC, S_CORD, S_ANG, S_NW, S_WRN, S_DONE
    } t_state;

    typedef enum logic [1:0] {SQ_U, SQ_V, SQ_S} t_sqk;

    t_state                  r_state;
    logic [4:0]              r_cnt;
    t_cmd                    r_cmd;
    logic [1:0]              r_cor;
    logic signed [15:0]      r_p [3][3];
    logic signed [34:0]      r_n [3];
    logic [33:0]             r_uu;
    logic [33:0]             r_vv;
    logic signed [34:0]      r_dot;
    logic [16:0]             r_su;
    logic [16:0]             r_sv;
    logic [33:0]             r_lp;
    logic [33:0]             r_rem;
    logic [13:0]             r_q;
    logic signed [15:0]      r_c;
    logic [33:0]             r_sq_n;
    logic [34:0]             r_sq_res;
    logic [33:0]             r_sq_bit;
    t_sqk                    r_sqk;
    logic signed [29:0]      r_x;
    logic signed [29:0]      r_y;
    logic signed [19:0]      r_ang;
    logic [15:0]             r_w;
    logic signed [ACC_W-1:0] r_nacc [3];
    logic                    r_sat;
    logic signed [52:0]      r_prod;
    logic signed [ACC_W-1:0] r_rx;
    logic signed [ACC_W-1:0] r_ry;
    logic signed [ACC_W-1:0] r_rz;
    logic                    r_ovalid;
    logic signed [ACC_W-1:0] r_ox;
    logic signed [ACC_W-1:0] r_oy;
    logic signed [ACC_W-1:0] r_oz;
    logic                    r_osat;

    logic [1:0]              j1;
    logic [1:0]              j2;
    logic signed [16:0]      u [3];
    logic signed [16:0]      v [3];
    logic signed [16:0]      e [3];
    logic signed [16:0]      f [3];
    logic signed [34:0]      mul_a;
    logic signed [17:0]      mul_b;
    logic [4:0]              prev;
    logic [IDX_W-1:0]        cidx;
    logic [IDX_W-1:0]        pos_raddr;
    logic [IDX_W-1:0]        nrm_addr;
    logic [IDX_W-1:0]        nrm_raddr;
    logic [47:0]             pos_rdata;
    logic [143:0]            nrm_rdata;
    logic [34:0]             sq_sum;
    logic                    sq_ge;
    logic [33:0]             sq_n_nx;
    logic [34:0]             sq_res_nx;
    logic [33:0]             lp_f;
    logic [33:0]             mag;
    logic [34:0]             rem2;
    logic                    div_ge;
    logic [13:0]             q_nx;
    logic signed [29:0]      cx;
    logic signed [29:0]      sy;
    logic signed [29:0]      xs;
    logic signed [29:0]      ys;
    logic signed [19:0]      at;
    logic [18:0]             a_pos;
    logic [18:0]             a_rnd;
    logic [16:0]             ar;
    logic [15:0]             w_nx;
    logic signed [52:0]      rnd;
    logic signed [38:0]      term;
    logic signed [ACC_W-1:0] acc_old;
    logic signed [48:0]      acc_sum;
    logic signed [ACC_W-1:0] acc_nx;
    logic                    acc_clip;

    function automatic logic signed [16:0] sub17(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
        return {a[15], a} - {b[15], b};
    endfunction

    // Edge vectors of the current corner and of the cross product.
    always_comb begin
        j1 = (r_cor == 2'd2) ? 2'd0 : r_cor + 2'd1;
        j2 = (r_cor == 2'd0) ? 2'd2 : r_cor - 2'd1;
        for (int k = 0; k < 3; k++) begin
            u[k] = sub17(r_p[j1][k], r_p[r_cor][k]);
            v[k] = sub17(r_p[j2][k], r_p[r_cor][k]);
            e[k] = sub17(r_p[2][k], r_p[0][k]);
            f[k] = sub17(r_p[1][k], r_p[0][k]);
        end
    end

    assign prev = r_cnt - 5'd1;

    // Operand selection for the one shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CROSS: begin
                case (r_cnt[2:0])
                    3'd0:    begin mul_a = 35'(e[1]); mul_b = 18'(f[2]); end
                    3'd1:    begin mul_a = 35'(e[2]); mul_b = 18'(f[1]); end
                    3'd2:    begin mul_a = 35'(e[2]); mul_b = 18'(f[0]); end
                    3'd3:    begin mul_a = 35'(e[0]); mul_b = 18'(f[2]); end
                    3'd4:    begin mul_a = 35'(e[0]); mul_b = 18'(f[1]); end
                    default: begin mul_a = 35'(e[1]); mul_b = 18'(f[0]); end
                endcase
            end
            S_LEN: begin
                case (r_cnt[3:0])
                    4'd0:    begin mul_a = 35'(u[0]); mul_b = 18'(u[0]); end
                    4'd1:    begin mul_a = 35'(u[1]); mul_b = 18'(u[1]); end
                    4'd2:    begin mul_a = 35'(u[2]); mul_b = 18'(u[2]); end
                    4'd3:    begin mul_a = 35'(v[0]); mul_b = 18'(v[0]); end
                    4'd4:    begin mul_a = 35'(v[1]); mul_b = 18'(v[1]); end
                    4'd5:    begin mul_a = 35'(v[2]); mul_b = 18'(v[2]); end
                    4'd6:    begin mul_a = 35'(u[0]); mul_b = 18'(v[0]); end
                    4'd7:    begin mul_a = 35'(u[1]); mul_b = 18'(v[1]); end
                    default: begin mul_a = 35'(u[2]); mul_b = 18'(v[2]); end
                endcase
            end
            S_LP: begin
                mul_a = 35'({1'b0, r_su});
                mul_b = {1'b0, r_sv};
            end
            S_CC: begin
                mul_a = 35'(r_c);
                mul_b = 18'(r_c);
            end
            S_NW: begin
                mul_b = {2'b00, r_w};
                case (r_cnt[1:0])
                    2'd0:    mul_a = r_n[0];
                    2'd1:    mul_a = r_n[1];
                    default: mul_a = r_n[2];
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Memory addressing.
    always_comb begin
        case (r_cor)
            2'd0:    cidx = r_cmd.idx_a;
            2'd1:    cidx = r_cmd.idx_b;
            default: cidx = r_cmd.idx_c;
        endcase
        case (r_cnt[1:0])
            2'd0:    pos_raddr = r_cmd.idx_a;
            2'd1:    pos_raddr = r_cmd.idx_b;
            default: pos_raddr = r_cmd.idx_c;
        endcase
        nrm_addr  = (r_state == S_LOAD) ? r_cmd.idx_a : cidx;
        nrm_raddr = (r_state == S_READ) ? r_cmd.idx_a : cidx;
    end

    awvn_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LOAD),
        .i_waddr (r_cmd.idx_a),
        .i_wdata ({r_cmd.pos_z, r_cmd.pos_y, r_cmd.pos_x}),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    awvn_ram #(.WIDTH(144), .DEPTH(MAX_VERTICES)) u_nrm_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_LOAD) || (r_state == S_WRN)),
        .i_waddr (nrm_addr),
        .i_wdata ((r_state == S_LOAD) ? 144'd0 : {r_nacc[2], r_nacc[1], r_nacc[0]}),
        .i_raddr (nrm_raddr),
        .o_rdata (nrm_rdata)
    );

    // One step of the bit-pair square root.
    always_comb begin
        sq_sum    = r_sq_res + {1'b0, r_sq_bit};
        sq_ge     = ({1'b0, r_sq_n} >= sq_sum);
        sq_n_nx   = sq_ge ? (r_sq_n - sq_sum[33:0]) : r_sq_n;
        sq_res_nx = sq_ge ? ((r_sq_res >> 1) + {1'b0, r_sq_bit}) : (r_sq_res >> 1);
    end

    // Length product floor, cosine magnitude and one quotient bit.
    always_comb begin
        lp_f   = (r_prod[33:0] < LEN_FLOOR) ? LEN_FLOOR : r_prod[33:0];
        mag    = r_dot[34] ? 34'(-r_dot) : r_dot[33:0];
        rem2   = {r_rem, 1'b0};
        div_ge = (rem2 >= {1'b0, r_lp});
        q_nx   = {r_q[12:0], div_ge};
    end

    // Rotation step and angle rounding.
    always_comb begin
        cx    = {{2{r_c[15]}}, r_c, 12'd0};
        sy    = {3'd0, sq_res_nx[14:0], 12'd0};
        xs    = r_x >>> r_cnt[3:0];
        ys    = r_y >>> r_cnt[3:0];
        at    = $signed({4'd0, atan_q16(r_cnt[3:0])});
        a_pos = r_ang[19] ? 19'd0 : r_ang[18:0];
        a_rnd = a_pos + 19'd2;
        ar    = a_rnd[18:2];
        if (ar > PI_Q14) begin
            w_nx = PI_Q14[15:0];
        end else if (ar == 17'd0) begin
            w_nx = ANGLE_MIN;
        end else begin
            w_nx = ar[15:0];
        end
    end

    // Weighted term, rounded half up, added into the old accumulator with clipping.
    always_comb begin
        rnd  = r_prod + 53'sd8192;
        term = rnd[52:14];
        case (prev[1:0])
            2'd0:    acc_old = nrm_rdata[47:0];
            2'd1:    acc_old = nrm_rdata[95:48];
            default: acc_old = nrm_rdata[143:96];
        endcase
        acc_sum  = {acc_old[47], acc_old} + {{10{term[38]}}, term};
        acc_clip = (acc_sum[48] != acc_sum[47]);
        if (!acc_clip) begin
            acc_nx = acc_sum[47:0];
        end else if (acc_sum[48]) begin
            acc_nx = {1'b1, 47'd0};
        end else begin
            acc_nx = {1'b0, {47{1'b1}}};
        end
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_rx  <= '0;
                    r_ry  <= '0;
                    r_rz  <= '0;
                    r_sat <= 1'b0;
                    r_cor <= 2'd0;
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        case (i_cmd.kind)
                            OP_LOAD: r_state <= S_LOAD;
                            OP_TRI:  r_state <= S_PRD;
                            OP_READ: r_state <= S_READ;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_state <= S_DONE;
                end
                S_READ: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_rx    <= nrm_rdata[47:0];
                        r_ry    <= nrm_rdata[95:48];
                        r_rz    <= nrm_rdata[143:96];
                        r_state <= S_DONE;
                    end
                end
                S_PRD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt != 5'd0) begin
                        r_p[prev[1:0]][0] <= pos_rdata[15:0];
                        r_p[prev[1:0]][1] <= pos_rdata[31:16];
                        r_p[prev[1:0]][2] <= pos_rdata[47:32];
                    end
                    if (r_cnt == 5'd3) begin
                        r_cnt   <= '0;
                        r_n[0]  <= '0;
                        r_n[1]  <= '0;
                        r_n[2]  <= '0;
                        r_state <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt != 5'd0) begin
                        if (prev[0]) begin
                            r_n[prev[2:1]] <= r_n[prev[2:1]] - r_prod[34:0];
                        end else begin
                            r_n[prev[2:1]] <= r_n[prev[2:1]] + r_prod[34:0];
                        end
                    end
                    if (r_cnt == 5'd6) begin
                        r_cnt   <= '0;
                        r_uu    <= '0;
                        r_vv    <= '0;
                        r_dot   <= '0;
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt != 5'd0) begin
                        case (prev[3:0])
                            4'd0, 4'd1, 4'd2: r_uu  <= r_uu + r_prod[33:0];
                            4'd3, 4'd4, 4'd5: r_vv  <= r_vv + r_prod[33:0];
                            default:          r_dot <= r_dot + r_prod[34:0];
                        endcase
                    end
                    if (r_cnt == 5'd9) begin
                        r_cnt    <= '0;
                        r_sq_n   <= r_uu;
                        r_sq_res <= '0;
                        r_sq_bit <= SQ_BIT0;
                        r_sqk    <= SQ_U;
                        r_state  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_cnt    <= r_cnt + 5'd1;
                    r_sq_n   <= sq_n_nx;
                    r_sq_res <= sq_res_nx;
                    r_sq_bit <= r_sq_bit >> 2;
                    if (r_cnt == 5'd16) begin
                        r_cnt <= '0;
                        case (r_sqk)
                            SQ_U: begin
                                r_su     <= sq_res_nx[16:0];
                                r_sq_n   <= r_vv;
                                r_sq_res <= '0;
                                r_sq_bit <= SQ_BIT0;
                                r_sqk    <= SQ_V;
                            end
                            SQ_V: begin
                                r_sv    <= sq_res_nx[16:0];
                                r_state <= S_LP;
                            end
                            default: begin
                                // A negative cosine starts a quarter turn ahead.
                                if (r_c[15]) begin
                                    r_x   <= sy;
                                    r_y   <= -cx;
                                    r_ang <= HALF_PI_Q16;
                                end else begin
                                    r_x   <= cx;
                                    r_y   <= sy;
                                    r_ang <= '0;
                                end
                                r_state <= S_CORD;
                            end
                        endcase
                    end
                end
                S_LP: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_cnt <= '0;
                        r_lp  <= lp_f;
                        r_rem <= mag;
                        r_q   <= '0;
                        if (mag >= lp_f) begin
                            r_c     <= r_dot[34] ? -ONE_Q14 : ONE_Q14;
                            r_state <= S_CC;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    r_rem <= div_ge ? 34'(rem2 - {1'b0, r_lp}) : rem2[33:0];
                    r_q   <= q_nx;
                    if (r_cnt == 5'd13) begin
                        r_cnt   <= '0;
                        r_c     <= r_dot[34] ? -$signed({2'b00, q_nx})
                                             : $signed({2'b00, q_nx});
                        r_state <= S_CC;
                    end
                end
                S_CC: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd1) begin
                        r_cnt    <= '0;
                        r_sq_n   <= ONE_Q28 - r_prod[33:0];
                        r_sq_res <= '0;
                        r_sq_bit <= SQ_BIT0;
                        r_sqk    <= SQ_S;
                        r_state  <= S_SQRT;
                    end
                end
                S_CORD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (!r_y[29]) begin
                        r_x   <= r_x + ys;
                        r_y   <= r_y - xs;
                        r_ang <= r_ang + at;
                    end else begin
                        r_x   <= r_x - ys;
                        r_y   <= r_y + xs;
                        r_ang <= r_ang - at;
                    end
                    if (r_cnt == 5'd15) begin
                        r_cnt   <= '0;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_w     <= w_nx;
                    r_state <= S_NW;
                end
                S_NW: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt != 5'd0) begin
                        r_nacc[prev[1:0]] <= acc_nx;
                        if (acc_clip) begin
                            r_sat <= 1'b1;
                        end
                    end
                    if (r_cnt == 5'd3) begin
                        r_cnt   <= '0;
                        r_state <= S_WRN;
                    end
                end
                S_WRN: begin
                    if (r_cor == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cor   <= r_cor + 2'd1;
                        r_uu    <= '0;
                        r_vv    <= '0;
                        r_dot   <= '0;
                        r_state <= S_LEN;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_ox     <= r_rx;
                        r_oy     <= r_ry;
                        r_oz     <= r_rz;
                        r_osat   <= r_sat;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_normal_x  = r_ox;
    assign o_normal_y  = r_oy;
    assign o_normal_z  = r_oz;
    assign o_saturated = r_osat;

endmodule

/* tb/sv/awvn_checker.sv */
`timescale 1ns / 1ps

module awvn_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_stall,
    input  logic [1:0]                         i_opcode,
    input  logic [awvn_pkg::INDEX_W-1:0]       i_index_a,
    input  logic [awvn_pkg::INDEX_W-1:0]       i_index_b,
    input  logic [awvn_pkg::INDEX_W-1:0]       i_index_c,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_pos_z,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic signed [awvn_pkg::ACC_W-1:0]  o_normal_x,
    input  logic signed [awvn_pkg::ACC_W-1:0]  o_normal_y,
    input  logic signed [awvn_pkg::ACC_W-1:0]  o_normal_z,
    input  logic                               o_saturated,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import awvn_pkg::*;

    typedef struct {
        logic signed [ACC_W-1:0] nx;
        logic signed [ACC_W-1:0] ny;
        logic signed [ACC_W-1:0] nz;
        logic                    sat;
    } t_normal_word;

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint ARCTAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                           256, 128, 64, 32, 16, 8, 4, 2};

    longint       vert_pos [MAX_VERTICES][3];
    longint       normal_acc [MAX_VERTICES][3];
    t_normal_word normal_fifo [$];
    int           fails;

    assign o_fail_count = fails;
    assign o_pending    = normal_fifo.size();

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Interior angle in Q2.14 from a Q2.14 cosine, by CORDIC vectoring on (cos, sin).
    function automatic longint angle_from_cos(input longint c);
        longint x, y, a, xn, t;
        x = c * 4096;
        y = longint'(int_sqrt(longint'(64'd1 << 28) - c * c)) * 4096;
        a = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            a = 102944;
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                a  = a + ARCTAN_Q16[i];
            end else begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                a  = a - ARCTAN_Q16[i];
            end
            x = xn;
        end
        if (a < 0) a = 0;
        a = (a + 2) >>> 2;
        if (a > 51472) a = 51472;
        if (a == 0) a = 2;
        return a;
    endfunction

    function automatic longint corner_weight(input longint u [3], input longint v [3]);
        longint          dot;
        longint unsigned uu, vv, lp, mag, q;
        uu  = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        vv  = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        dot = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
        lp  = int_sqrt(uu) * int_sqrt(vv);
        mag = (dot < 0) ? -dot : dot;
        if (lp < 7) lp = 7;
        q = (mag << 14) / lp;
        if (q > 16384) q = 16384;
        return angle_from_cos((dot < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint clamp_add(input longint acc, input longint cr, input longint w,
                                         inout logic sat);
        longint sum;
        sum = acc + ((cr * w + 8192) >>> 14);
        if (sum > ACC_HI) begin
            sat = 1'b1;
            return ACC_HI;
        end
        if (sum < ACC_LO) begin
            sat = 1'b1;
            return ACC_LO;
        end
        return sum;
    endfunction

    function automatic t_normal_word predict_normal(input t_op op, input int ia, input int ib,
                                                     input int ic, input longint px,
                                                     input longint py, input longint pz);
        t_normal_word r;
        longint       p [3][3];
        longint       e [3], f [3], cr [3], u [3], v [3];
        longint       w;
        int           corner [3];
        logic         sat;
        r   = '{nx: '0, ny: '0, nz: '0, sat: 1'b0};
        sat = 1'b0;
        case (op)
            OP_LOAD: begin
                vert_pos[ia] = '{px, py, pz};
                normal_acc[ia] = '{0, 0, 0};
            end
            OP_TRI: begin
                corner = '{ia, ib, ic};
                for (int j = 0; j < 3; j++) p[j] = vert_pos[corner[j]];
                for (int k = 0; k < 3; k++) begin
                    e[k] = p[2][k] - p[0][k];
                    f[k] = p[1][k] - p[0][k];
                end
                cr[0] = e[1]*f[2] - e[2]*f[1];
                cr[1] = e[2]*f[0] - e[0]*f[2];
                cr[2] = e[0]*f[1] - e[1]*f[0];
                // Corners are applied in order, so a repeated vertex collects every term.
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        u[k] = p[(j + 1) % 3][k] - p[j][k];
                        v[k] = p[(j + 2) % 3][k] - p[j][k];
                    end
                    w = corner_weight(u, v);
                    for (int k = 0; k < 3; k++)
                        normal_acc[corner[j]][k] = clamp_add(normal_acc[corner[j]][k], cr[k],
                                                             w, sat);
                end
                r.sat = sat;
            end
            OP_READ: begin
                r.nx = normal_acc[ia][0][ACC_W-1:0];
                r.ny = normal_acc[ia][1][ACC_W-1:0];
                r.nz = normal_acc[ia][2][ACC_W-1:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_normal_word want;
        if (!i_rst_n) begin
            normal_fifo.delete();
            fails <= 0;
        end else begin
            if (i_valid && !o_stall)
                normal_fifo = {normal_fifo,
                               predict_normal(t_op'(i_opcode), int'(i_index_a),
                                              int'(i_index_b), int'(i_index_c),
                                              longint'(i_pos_x), longint'(i_pos_y),
                                              longint'(i_pos_z))};
            if (o_valid && !i_stall) begin
                if (normal_fifo.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result word with nothing expected", $time);
                    fails <= fails + 1;
                end else begin
                    want = normal_fifo.pop_front();
                    if (o_normal_x !== want.nx || o_normal_y !== want.ny ||
                        o_normal_z !== want.nz || o_saturated !== want.sat) begin
                        if (fails < 10)
                            $display("%0t: expected %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                                     $time, want.nx, want.ny, want.nz, want.sat,
                                     o_normal_x, o_normal_y, o_normal_z, o_saturated);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import awvn_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [1:0]              i_opcode = OP_NONE;
    logic [INDEX_W-1:0]      i_index_a = '0;
    logic [INDEX_W-1:0]      i_index_b = '0;
    logic [INDEX_W-1:0]      i_index_c = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic signed [POS_W-1:0] i_pos_z = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [ACC_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic                    o_saturated;
    int                      fail_count, pending;
    logic                    hold_request = 1'b0;

    int vertex_list [$];
    bit vertex_loaded [MAX_VERTICES];

    always #5 i_clk = ~i_clk;

    angle_weighted_vertex_normals_unit dut (.*);

    awvn_checker u_checker (.*, .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        #40ms;
        $display("angle_weighted_vertex_normals_unit verification failed");
        $finish;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: segments of no, light or heavy stalling, plus one long hold-off on request.
    initial begin
        int seg_len, density;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (3000) begin
                    @(posedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            seg_len = $urandom_range(30, 400);
            density = $urandom_range(0, 2) * 40;
            repeat (seg_len) begin
                @(posedge i_clk);
                if ($urandom_range(0, 99) < density)
                    i_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b1;
                else
                    i_stall <= 1'b0;
                if (density > 0 && $urandom_range(0, 199) == 0)
                    repeat ($urandom_range(20, 80)) begin
                        @(posedge i_clk);
                        i_stall <= 1'b1;
                    end
            end
        end
    end

    task automatic send_word(input t_op op, input int ia, input int ib, input int ic,
                             input int px, input int py, input int pz);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode  <= op;
        i_index_a <= INDEX_W'(ia);
        i_index_b <= INDEX_W'(ib);
        i_index_c <= INDEX_W'(ic);
        i_pos_x   <= POS_W'(px);
        i_pos_y   <= POS_W'(py);
        i_pos_z   <= POS_W'(pz);
        i_valid   <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (op == OP_LOAD && !vertex_loaded[ia]) begin
            vertex_loaded[ia] = 1'b1;
            vertex_list = {vertex_list, ia};
        end
    endtask

    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom_range(0, 4095) - 2048;
        if (r < 9) return $urandom_range(0, 65535) - 32768;
        return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    endfunction

    function automatic int pick_vertex(input int hot_count);
        if ($urandom_range(0, 3) != 0 && hot_count > 0)
            return vertex_list[$urandom_range(0, hot_count - 1)];
        return vertex_list[$urandom_range(0, vertex_list.size() - 1)];
    endfunction

    initial begin
        int r, hot;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes of position and index, a right triangle, a flat one, a straight angle.
        send_word(OP_LOAD, 0, 0, 0, -32768, -32768, -32768);
        send_word(OP_LOAD, 1023, 0, 0, 32767, 32767, 32767);
        send_word(OP_LOAD, 1, 0, 0, 32767, -32768, 0);
        send_word(OP_LOAD, 2, 0, 0, 0, 0, 0);
        send_word(OP_LOAD, 3, 0, 0, 256, 0, 0);
        send_word(OP_LOAD, 4, 0, 0, 0, 256, 0);
        send_word(OP_LOAD, 5, 0, 0, 512, 0, 0);
        send_word(OP_TRI, 2, 3, 4, 0, 0, 0);
        send_word(OP_TRI, 2, 3, 5, 0, 0, 0);
        send_word(OP_TRI, 3, 5, 2, 0, 0, 0);
        send_word(OP_TRI, 2, 2, 4, 0, 0, 0);
        send_word(OP_TRI, 0, 1023, 1, 0, 0, 0);
        send_word(OP_TRI, 1023, 0, 1023, 0, 0, 0);
        send_word(OP_READ, 2, 0, 0, 0, 0, 0);
        send_word(OP_READ, 3, 0, 0, 0, 0, 0);
        send_word(OP_READ, 4, 0, 0, 0, 0, 0);
        send_word(OP_READ, 0, 0, 0, 0, 0, 0);
        send_word(OP_READ, 1023, 0, 0, 0, 0, 0);
        send_word(OP_NONE, 1023, 1023, 1023, -1, -1, -1);
        send_word(OP_LOAD, 2, 0, 0, -256, 128, 64);
        send_word(OP_READ, 2, 0, 0, 0, 0, 0);
        send_word(OP_READ, 1, 0, 0, 0, 0, 0);

        hot = vertex_list.size();
        for (int n = 0; n < 1200; n++) begin
            if (n == 300) hold_request = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 25) begin
                // Mostly reload a working vertex; sometimes open a fresh index anywhere.
                if ($urandom_range(0, 2) == 0)
                    send_word(OP_LOAD, $urandom_range(0, MAX_VERTICES - 1), 0, 0,
                              rand_coord(), rand_coord(), rand_coord());
                else
                    send_word(OP_LOAD, pick_vertex(hot), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
            end else if (r < 70) begin
                send_word(OP_TRI, pick_vertex(hot), pick_vertex(hot), pick_vertex(hot),
                          rand_coord(), rand_coord(), rand_coord());
            end else if (r < 95) begin
                send_word(OP_READ, pick_vertex(hot), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
            end else begin
                send_word(OP_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
            end
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0)
            $display("angle_weighted_vertex_normals_unit verification clean");
        else
            $display("angle_weighted_vertex_normals_unit verification failed");
        $finish;
    end

endmodule
